@@ design/unsigned_number_text_parser_assert.svh @@
// Assertion macros for the parser RTL (used by unp_core).
// No dependencies; compiled out when SYNTH is defined.
`ifndef UNSIGNED_NUMBER_TEXT_PARSER_ASSERT_SVH
`define UNSIGNED_NUMBER_TEXT_PARSER_ASSERT_SVH
`ifndef SYNTH
`define UNP_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("unp assertion failed");
`define UNP_ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("unp forbidden condition");
`else
`define UNP_ASSERT(lbl, clk, rst, prop)
`define UNP_ASSERT_NEVER(lbl, clk, rst, expr)
`endif
`endif

@@ design/unp_pkg.sv @@
// Shared types, constants and character helpers for the number text parser.
// No dependencies.
package unp_pkg;

   localparam int VALUE_BITS_DEF  = 64;
   localparam int OFFSET_BITS_DEF = 16;
   localparam int CH_BITS         = 8;
   localparam int BASE_BITS       = 6;
   localparam int VALUE_OUT_BITS  = 64;
   localparam int OFFSET_OUT_BITS = 16;

   localparam logic [BASE_BITS-1:0] RADIX_RESET = 6'd10;
   localparam logic [BASE_BITS-1:0] BASE_AUTO   = 6'd0;
   localparam logic [BASE_BITS-1:0] BASE_OCT    = 6'd8;
   localparam logic [BASE_BITS-1:0] BASE_DEC    = 6'd10;
   localparam logic [BASE_BITS-1:0] BASE_HEX    = 6'd16;
   localparam logic [BASE_BITS-1:0] BASE_MAX    = 6'd36;
   localparam logic [BASE_BITS-1:0] NO_DIGIT    = 6'd36;

   localparam logic [CH_BITS-1:0] CH_SPACE  = 8'h20;
   localparam logic [CH_BITS-1:0] CH_TAB    = 8'h09;
   localparam logic [CH_BITS-1:0] CH_CR     = 8'h0D;
   localparam logic [CH_BITS-1:0] CH_PLUS   = 8'h2B;
   localparam logic [CH_BITS-1:0] CH_MINUS  = 8'h2D;
   localparam logic [CH_BITS-1:0] CH_ZERO   = 8'h30;
   localparam logic [CH_BITS-1:0] CH_NINE   = 8'h39;
   localparam logic [CH_BITS-1:0] CH_LOW_A  = 8'h61;
   localparam logic [CH_BITS-1:0] CH_LOW_Z  = 8'h7A;
   localparam logic [CH_BITS-1:0] CH_UP_A   = 8'h41;
   localparam logic [CH_BITS-1:0] CH_UP_Z   = 8'h5A;
   localparam logic [CH_BITS-1:0] CH_LOW_X  = 8'h78;
   localparam logic [CH_BITS-1:0] CH_UP_X   = 8'h58;

   typedef struct packed {
      logic [CH_BITS-1:0] ch;
      logic               first;
      logic               last;
   } item_type;

   typedef struct packed {
      logic [VALUE_OUT_BITS-1:0]  value;
      logic [OFFSET_OUT_BITS-1:0] end_offset;
      logic                       converted;
      logic                       overflowed;
      logic                       bad_radix;
   } result_type;

   // digit value 0..35, or NO_DIGIT for anything else
   function automatic logic [BASE_BITS-1:0] digit_of(input logic [CH_BITS-1:0] c);
      logic [CH_BITS-1:0] d;
      d = '0;
      if (c inside {[CH_ZERO:CH_NINE]}) begin
         d = c - CH_ZERO;
      end else if (c inside {[CH_LOW_A:CH_LOW_Z]}) begin
         d = c - CH_LOW_A + 8'd10;
      end else if (c inside {[CH_UP_A:CH_UP_Z]}) begin
         d = c - CH_UP_A + 8'd10;
      end else begin
         d = {2'b00, NO_DIGIT};
      end
      return d[BASE_BITS-1:0];
   endfunction

   function automatic logic base_invalid(input logic [BASE_BITS-1:0] b);
      return (b == 6'd1) || (b > BASE_MAX);
   endfunction

endpackage

@@ design/unp_in_reg.sv @@
// Input register for the character stream.
// Depends on unp_pkg.
module unp_in_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  unp_pkg::item_type req_item,
   input  logic              take,
   output logic              item_valid,
   output unp_pkg::item_type item
);

   logic              valid_ff, valid_in;
   unp_pkg::item_type item_ff;

   assign req_ready  = !valid_ff || take;
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_comb begin
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload: hold unless a new word is taken
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_item;
      end
   end

endmodule

@@ design/unp_core.sv @@
// Conversion state, radix register and per-character step logic.
// Depends on unp_pkg and unsigned_number_text_parser_assert.svh.
`include "unsigned_number_text_parser_assert.svh"
module unp_core #(
   parameter int VALUE_BITS  = unp_pkg::VALUE_BITS_DEF,
   parameter int OFFSET_BITS = unp_pkg::OFFSET_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   input  logic [unp_pkg::BASE_BITS-1:0]   csr_data,
   input  logic                            item_valid,
   input  unp_pkg::item_type               item,
   input  logic                            slot_free,
   output logic                            take,
   output logic                            res_load,
   output unp_pkg::result_type             result
);

   localparam int PW = VALUE_BITS + unp_pkg::BASE_BITS;
   localparam logic [OFFSET_BITS-1:0] OMAX = '1;
   localparam logic [VALUE_BITS-1:0]  VMAX = '1;

   localparam logic [2:0] PH_IDLE   = 3'd0;
   localparam logic [2:0] PH_WS     = 3'd1;
   localparam logic [2:0] PH_START  = 3'd2;
   localparam logic [2:0] PH_ZERO   = 3'd3;
   localparam logic [2:0] PH_ZX     = 3'd4;
   localparam logic [2:0] PH_DIGITS = 3'd5;

   logic [unp_pkg::BASE_BITS-1:0] radix_ff;
   logic [2:0]                    phase_ff, phase_in;
   logic [VALUE_BITS-1:0]         acc_ff, acc_in;
   logic [unp_pkg::BASE_BITS-1:0] base_ff, base_in;
   logic                          minus_ff, minus_in;
   logic                          digit_ff, digit_in;
   logic                          ovf_ff, ovf_in;
   logic [OFFSET_BITS-1:0]        count_ff, count_in;

   logic                          step_en, live, emit, start_path, digit_path, do_acc;
   logic [OFFSET_BITS-1:0]        idx, nxt, end_sel;
   logic [unp_pkg::BASE_BITS-1:0] d;
   logic [PW-1:0]                 prod;
   logic [VALUE_BITS-1:0]         v;

   assign step_en = item_valid && slot_free;
   assign take    = step_en;
   assign d       = unp_pkg::digit_of(item.ch);

   always_comb begin
      phase_in   = phase_ff;
      acc_in     = acc_ff;
      base_in    = base_ff;
      minus_in   = minus_ff;
      digit_in   = digit_ff;
      ovf_in     = ovf_ff;
      live       = 1'b1;
      emit       = 1'b0;
      start_path = 1'b0;
      digit_path = 1'b0;
      do_acc     = 1'b0;
      end_sel    = '0;
      prod       = '0;
      if (item.first) begin
         phase_in = PH_WS;
         acc_in   = '0;
         base_in  = radix_ff;
         minus_in = 1'b0;
         digit_in = 1'b0;
         ovf_in   = 1'b0;
         idx      = '0;
      end else begin
         idx = count_ff;
         if (phase_ff == PH_IDLE || phase_ff > PH_DIGITS) begin
            live = 1'b0;
         end
      end
      nxt      = (idx == OMAX) ? OMAX : idx + OFFSET_BITS'(1);
      count_in = live ? nxt : count_ff;

      case (phase_in)
         PH_WS: begin
            if (item.ch inside {unp_pkg::CH_SPACE, [unp_pkg::CH_TAB:unp_pkg::CH_CR]}) begin
               emit = item.last;
            end else if (item.ch == unp_pkg::CH_PLUS || item.ch == unp_pkg::CH_MINUS) begin
               minus_in = (item.ch == unp_pkg::CH_MINUS);
               phase_in = PH_START;
               emit     = item.last;
            end else begin
               start_path = 1'b1;
            end
         end
         PH_START: start_path = 1'b1;
         PH_ZERO: begin
            if (item.ch == unp_pkg::CH_LOW_X || item.ch == unp_pkg::CH_UP_X) begin
               if (item.last) begin
                  emit    = 1'b1;
                  end_sel = idx;
               end else begin
                  phase_in = PH_ZX;
               end
            end else begin
               digit_path = 1'b1;
            end
         end
         PH_ZX: begin
            if (d < unp_pkg::BASE_HEX) begin
               base_in  = unp_pkg::BASE_HEX;
               phase_in = PH_DIGITS;
               do_acc   = 1'b1;
               emit     = item.last;
               end_sel  = nxt;
            end else begin
               // point back at the 'x': only the zero was consumed
               emit    = 1'b1;
               end_sel = (idx == OMAX) ? OMAX : idx - OFFSET_BITS'(1);
            end
         end
         PH_DIGITS: digit_path = 1'b1;
         default: ;
      endcase

      if (start_path) begin
         if (unp_pkg::base_invalid(base_in)) begin
            emit = 1'b1;
         end else if ((base_in == unp_pkg::BASE_AUTO || base_in == unp_pkg::BASE_HEX)
                      && item.ch == unp_pkg::CH_ZERO) begin
            acc_in   = '0;
            digit_in = 1'b1;
            base_in  = (base_in == unp_pkg::BASE_AUTO) ? unp_pkg::BASE_OCT : unp_pkg::BASE_HEX;
            phase_in = PH_ZERO;
            emit     = item.last;
            end_sel  = nxt;
         end else begin
            if (base_in == unp_pkg::BASE_AUTO) begin
               base_in = unp_pkg::BASE_DEC;
            end
            digit_path = 1'b1;
         end
      end

      if (digit_path) begin
         phase_in = PH_DIGITS;
         if (d >= base_in) begin
            emit    = 1'b1;
            end_sel = idx;
         end else begin
            do_acc  = 1'b1;
            emit    = item.last;
            end_sel = nxt;
         end
      end

      // multiply-add; any carry beyond the value width saturates
      if (do_acc) begin
         digit_in = 1'b1;
         prod = PW'(acc_in) * PW'(base_in) + PW'(d);
         if (prod[PW-1:VALUE_BITS] != '0) begin
            ovf_in = 1'b1;
         end else if (!ovf_in) begin
            acc_in = prod[VALUE_BITS-1:0];
         end
      end

      if (emit) begin
         phase_in = PH_IDLE;
      end

      if (!live) begin
         phase_in = phase_ff;
         acc_in   = acc_ff;
         base_in  = base_ff;
         minus_in = minus_ff;
         digit_in = digit_ff;
         ovf_in   = ovf_ff;
         emit     = 1'b0;
      end
   end

   always_comb begin
      if (ovf_in) begin
         v = VMAX;
      end else if (minus_in) begin
         v = VALUE_BITS'(0) - acc_in;
      end else begin
         v = acc_in;
      end
      if (!digit_in) begin
         v = '0;
      end
      result.value      = unp_pkg::VALUE_OUT_BITS'(v);
      result.end_offset = digit_in ? unp_pkg::OFFSET_OUT_BITS'(end_sel) : '0;
      result.converted  = digit_in;
      result.overflowed = ovf_in;
      result.bad_radix  = unp_pkg::base_invalid(base_in);
   end

   assign res_load = step_en && emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= unp_pkg::RADIX_RESET;
      end else if (csr_valid) begin
         radix_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         acc_ff   <= '0;
         base_ff  <= '0;
         minus_ff <= 1'b0;
         digit_ff <= 1'b0;
         ovf_ff   <= 1'b0;
         count_ff <= '0;
      end else if (step_en) begin
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
         base_ff  <= base_in;
         minus_ff <= minus_in;
         digit_ff <= digit_in;
         ovf_ff   <= ovf_in;
         count_ff <= count_in;
      end
   end

   `UNP_ASSERT(a_ovf_needs_digit, clock, reset, res_load && result.overflowed |-> result.converted)
   `UNP_ASSERT_NEVER(a_bad_radix_no_digit, clock, reset, res_load && result.bad_radix && result.converted)
   `UNP_ASSERT(a_idle_after_result, clock, reset, res_load |=> phase_ff == PH_IDLE)
   `UNP_ASSERT(a_count_frozen_idle, clock, reset, step_en && !item.first && phase_ff == PH_IDLE |=> $stable(count_ff))

endmodule

@@ design/unp_out_reg.sv @@
// Result register towards the response stream.
// Depends on unp_pkg.
module unp_out_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  unp_pkg::result_type result,
   output logic                slot_free,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output unp_pkg::result_type rsp_result
);

   logic                valid_ff, valid_in;
   unp_pkg::result_type result_ff;

   assign slot_free  = !valid_ff || rsp_ready;
   assign rsp_valid  = valid_ff;
   assign rsp_result = result_ff;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result;
      end
   end

endmodule

@@ design/unsigned_number_text_parser.sv @@
// Unsigned number text parser: one character per cycle, one result per conversion.
// The word that ends a conversion passes through the input register, then the result register,
// before rsp_tvalid rises.
// Throughput: one character per cycle; a held result stalls the input once both registers fill.
// Reset (synchronous, active high) empties both registers, idles the parser, radix = 10.
// Depends on unp_pkg, unp_in_reg, unp_core, unp_out_reg.
module unsigned_number_text_parser #(
   parameter int VALUE_BITS  = unp_pkg::VALUE_BITS_DEF,
   parameter int OFFSET_BITS = unp_pkg::OFFSET_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [5:0]  csr_data,     // radix
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] ch
   input  logic [0:0]  req_tuser,    // [0] first
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,    // [63:0] value, [79:64] end_offset
   output logic [2:0]  rsp_tuser     // [0] converted, [1] overflowed, [2] bad_radix
);

   unp_pkg::item_type   req_item, item;
   unp_pkg::result_type result, rsp_result;
   logic                item_valid, take, res_load, slot_free;

   assign csr_ready      = 1'b1;
   assign req_item.ch    = req_tdata;
   assign req_item.first = req_tuser[0];
   assign req_item.last  = req_tlast;

   unp_in_reg u_in (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_item   (req_item),
      .take       (take),
      .item_valid (item_valid),
      .item       (item)
   );

   unp_core #(
      .VALUE_BITS  (VALUE_BITS),
      .OFFSET_BITS (OFFSET_BITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .item_valid (item_valid),
      .item       (item),
      .slot_free  (slot_free),
      .take       (take),
      .res_load   (res_load),
      .result     (result)
   );

   unp_out_reg u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (res_load),
      .result     (result),
      .slot_free  (slot_free),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_result (rsp_result)
   );

   assign rsp_tdata = {rsp_result.end_offset, rsp_result.value};
   assign rsp_tuser = {rsp_result.bad_radix, rsp_result.overflowed, rsp_result.converted};

endmodule
